@@ src/rti_pkg.sv @@
// Package for the radix integer-to-ASCII converter.
// Holds sizing constants, character codes, CSR map, FSM type and the glyph function.
// No dependencies.
package rti_pkg;

   // Input word and digit-serial divider sizing
   localparam int VALUE_BITS    = 32;
   localparam int STEP_BITS     = 8;
   localparam int STEPS         = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int QUO_BITS      = STEPS * STEP_BITS;
   localparam int STEP_CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int DIGIT_DEPTH   = VALUE_BITS;
   localparam int CNT_BITS      = $clog2(VALUE_BITS + 1);
   localparam int DIGIT_BITS    = 4;

   // Radix register
   localparam int RADIX_BITS = 5;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

   // Character codes
   localparam int CHAR_BITS = 7;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;

   // CSR map: register index is paddr[2]
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_RADIX = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } rti_state_type;

   // Digit value 0..15 to its ASCII glyph
   function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_UPPER_A + CHAR_BITS'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

@@ src/rti_channels.sv @@
// Valid/ready channel interfaces for the converter: request (integer) and response (character).
// Depends on rti_pkg for field widths.
interface rti_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [rti_pkg::VALUE_BITS-1:0]     value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rti_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rti_pkg::CHAR_BITS-1:0]       character;
   logic                                last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ src/radix_integer_to_ascii.sv @@
// Radix integer-to-ASCII converter: signed integer in, one character per response transaction.
// The divider works out each digit in STEPS byte-wide restoring-division steps; all digits are
// computed first, then emitted most significant first from a digit stack, led by a minus sign
// for a negative input.
// Throughput is set by the shared 8-bit-per-cycle remainder chain; one number at a time.
// Reset (synchronous, active high) clears the FSM and output valid and sets radix to 10.
module radix_integer_to_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   rti_req_if.sink                               req_ch,
   rti_rsp_if.source                             rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rti_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [rti_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [rti_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);
   import rti_pkg::*;

   rti_state_type                state_ff, state_in;
   logic [RADIX_BITS-1:0]        radix_ff, radix_in;
   logic [RADIX_BITS-1:0]        base_ff, base_in;
   logic [QUO_BITS-1:0]          quo_ff, quo_in;
   logic [DIGIT_BITS-1:0]        rem_ff, rem_in;
   logic                         nz_ff, nz_in;
   logic [STEP_CNT_BITS-1:0]     step_ff, step_in;
   logic                         neg_ff, neg_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [DIGIT_BITS-1:0]        dig_ff [DIGIT_DEPTH];
   logic [DIGIT_BITS-1:0]        dig_in [DIGIT_DEPTH];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]         rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         csr_wr;
   logic [VALUE_BITS-1:0]        raw;
   logic [VALUE_BITS-1:0]        mag;
   logic [RADIX_BITS-1:0]        eff_radix;
   logic [STEP_BITS-1:0]         qbits;
   logic [DIGIT_BITS-1:0]        rem_next;
   logic [DIGIT_BITS:0]          trial;
   logic                         load_ok;
   logic                         push;
   logic                         pop;

   // CSR port: zero wait state, writes land on the access phase
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_RADIX) ? CSR_DATA_BITS'(radix_ff) : '0;
   assign radix_in = (csr_wr && paddr[2] == REG_RADIX) ? pwdata[RADIX_BITS-1:0] : radix_ff;

   // Clamp the radix into two..sixteen
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   // Sign and magnitude; most negative value comes out as an unsigned magnitude
   assign raw = req_ch.value;
   assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

   // One byte of restoring division by the radix; remainder stays below sixteen
   always_comb begin
      rem_next = rem_ff;
      qbits    = '0;
      trial    = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
         trial = {rem_next, quo_ff[QUO_BITS-1-k]};
         if (trial >= base_ff) begin
            qbits[STEP_BITS-1-k] = 1'b1;
            trial = trial - base_ff;
         end
         rem_next = trial[DIGIT_BITS-1:0];
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = rsp_char_ff;
   assign rsp_ch.last_char = rsp_last_ff;
   assign load_ok          = ~rsp_valid_ff | rsp_ch.ready;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      nz_in        = nz_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      push         = 1'b0;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               base_in  = eff_radix;
               quo_in   = QUO_BITS'(mag);
               rem_in   = '0;
               nz_in    = 1'b0;
               step_in  = '0;
               neg_in   = raw[VALUE_BITS-1];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = (quo_ff << STEP_BITS) | QUO_BITS'(qbits);
            rem_in = rem_next;
            nz_in  = nz_ff | (|qbits);
            if (step_ff == STEP_CNT_BITS'(STEPS - 1)) begin
               // Division done: remainder is the next digit, quotient feeds the next pass
               push    = 1'b1;
               cnt_in  = cnt_ff + CNT_BITS'(1);
               rem_in  = '0;
               nz_in   = 1'b0;
               step_in = '0;
               if (!(nz_ff | (|qbits))) begin
                  state_in = ST_EMIT;
               end
            end else begin
               step_in = step_ff + STEP_CNT_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  pop         = 1'b1;
                  rsp_char_in = digit_glyph(dig_ff[0]);
                  rsp_last_in = (cnt_ff == CNT_BITS'(1));
                  cnt_in      = cnt_ff - CNT_BITS'(1);
                  if (cnt_ff == CNT_BITS'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Digit stack as a shift register: push at the bottom, most significant digit pops first
   always_comb begin
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         dig_in[i] = dig_ff[i];
      end
      if (push) begin
         dig_in[0] = rem_next;
         for (int i = 1; i < DIGIT_DEPTH; i++) begin
            dig_in[i] = dig_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < DIGIT_DEPTH - 1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         dig_in[DIGIT_DEPTH-1] = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         neg_ff       <= 1'b0;
         nz_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         neg_ff       <= neg_in;
         nz_ff        <= nz_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         dig_ff[i] <= dig_in[i];
      end
   end

endmodule

@@ dv/testbench.sv @@
// Testbench for radix_integer_to_ascii: signed integers in, ASCII digits out, checked per character.
// A scoreboard class predicts each digit string from the current radix; plain tasks drive the
// request channel and the APB-style register port. Depends on rti_pkg and rti_channels.
module testbench;
   import rti_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   localparam int LIMIT_CYCLES = 800_000;
   // drain already waits for every expected character, so a short pause after the last one is plenty
   localparam int DRAIN_CYCLES = 8;
   localparam int CHUNKS       = 5;
   localparam int CHUNK_ITEMS  = 21;
   localparam logic [CSR_ADDR_BITS-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
   // index 1: no register lives there, writes must be dropped
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = 3'd4;

   // Predicts the character stream and checks it in order
   class numeral_scoreboard;
      typedef struct packed {
         logic [CHAR_BITS-1:0] code;
         logic                 last;
      } glyph_type;

      glyph_type             pending_glyphs[$];
      logic [RADIX_BITS-1:0] radix_reg;
      string                 glyph_set;
      int                    errors;
      int                    values_seen;
      int                    chars_seen;

      function new();
         radix_reg   = RADIX_RESET;
         glyph_set   = "0123456789ABCDEF";
         errors      = 0;
         values_seen = 0;
         chars_seen  = 0;
      endfunction

      function void write_radix(logic [CSR_DATA_BITS-1:0] data);
         radix_reg = data[RADIX_BITS-1:0];
      endfunction

      function int unsigned pending();
         return pending_glyphs.size();
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Spell out one accepted integer in the current radix
      function void accept_value(logic [VALUE_BITS-1:0] raw);
         logic [VALUE_BITS-1:0] mag;
         logic [VALUE_BITS-1:0] base;
         logic [CHAR_BITS-1:0]  digits[$];
         logic                  neg;
         glyph_type             g;
         // out-of-range register values clamp to the nearest legal base
         if (radix_reg < RADIX_MIN)      base = VALUE_BITS'(RADIX_MIN);
         else if (radix_reg > RADIX_MAX) base = VALUE_BITS'(RADIX_MAX);
         else                            base = VALUE_BITS'(radix_reg);
         neg = raw[VALUE_BITS-1];
         // unsigned magnitude: the most negative value stays exact
         mag = neg ? -raw : raw;
         do begin
            digits.push_front(CHAR_BITS'(glyph_set[mag % base]));
            mag = mag / base;
         end while (mag != 0);
         if (neg) begin
            g.code = CHAR_MINUS;
            g.last = 1'b0;
            pending_glyphs = {pending_glyphs, g};
         end
         foreach (digits[i]) begin
            g.code = digits[i];
            g.last = (i == digits.size() - 1);
            pending_glyphs = {pending_glyphs, g};
         end
         values_seen++;
      endfunction

      task check_character(logic [CHAR_BITS-1:0] code, logic last);
         glyph_type want;
         chars_seen++;
         if (pending_glyphs.size() == 0) begin
            report($sformatf("character 0x%02h last=%0b with nothing expected", code, last));
            return;
         end
         want = pending_glyphs.pop_front();
         if (code !== want.code)
            report($sformatf("character 0x%02h, expected 0x%02h", code, want.code));
         if (last !== want.last)
            report($sformatf("last_char %0b on 0x%02h, expected %0b", last, code, want.last));
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       radix_writes;

   numeral_scoreboard board = new();

   rti_req_if req_bus();
   rti_rsp_if rsp_bus();

   radix_integer_to_ascii dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timeout: run did not finish");
      $display("Some tests failed");
      $finish;
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Observe register writes and both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready && (paddr >> 2) == REG_RADIX)
            board.write_radix(pwdata);
         if (req_bus.valid && req_bus.ready)
            board.accept_value(req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_character(rsp_bus.character, rsp_bus.last_char);
      end
   end

   task automatic send_value(input logic [VALUE_BITS-1:0] v);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and let every expected character come out
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Read back the radix register and compare with the predicted copy
   task automatic check_radix_readback();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= RADIX_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_BITS'(board.radix_reg))
         board.report($sformatf("radix reads 0x%08h, expected 0x%08h",
                                prdata, CSR_DATA_BITS'(board.radix_reg)));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Upper data bits are random noise that the register must drop
   task automatic set_radix(input int unsigned r);
      logic [CSR_DATA_BITS-1:0] data;
      data = CSR_DATA_BITS'($urandom);
      data[RADIX_BITS-1:0] = RADIX_BITS'(r);
      drain();
      csr_write(RADIX_ADDR, data);
      radix_writes++;
      check_radix_readback();
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom_range(1000);
         6, 7:       v = -$urandom_range(1000, 1);
         8: begin
            // spread magnitudes over every digit count
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) v = -v;
         end
         default: begin
            case ($urandom_range(3))
               0:       v = '0;
               1:       v = {1'b1, {(VALUE_BITS - 1){1'b0}}};
               2:       v = {1'b0, {(VALUE_BITS - 1){1'b1}}};
               default: v = '1;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic int unsigned pick_radix();
      if ($urandom_range(4) == 0) return $urandom_range(31);
      return $urandom_range(16, 2);
   endfunction

   initial begin
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 28;
      recv_idle_pct = 52;
      radix_writes  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset radix of ten, zero, extremes, sign handling
      check_radix_readback();
      send_value(32'd0);
      send_value(32'd1);
      send_value(-32'sd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(-32'sd10);
      send_value(32'd123456789);

      // Hex letters and the most negative value in base 16
      set_radix(16);
      send_value(32'd255);
      send_value(32'h00AB_CDEF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);

      // Base 2: the longest strings, 33 characters for the most negative value
      set_radix(2);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd0);
      send_value(32'd5);

      // Register values below two and above sixteen clamp
      set_radix(0);
      send_value(32'd6);
      set_radix(1);
      send_value(-32'sd3);
      set_radix(31);
      send_value(32'hFEDC_BA98);
      set_radix(17);
      send_value(32'd255);

      // Write to an unused index must leave the radix alone
      drain();
      csr_write(SPARE_ADDR, 32'd3);
      check_radix_readback();
      send_value(32'd100);

      // Random: three idle profiles, radix changed between chunks
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            set_radix(pick_radix());
            repeat (CHUNK_ITEMS) send_value(pick_value());
         end
      end

      drain();
      $display("Converted %0d integers into %0d characters over %0d radix writes,",
               board.values_seen, board.chars_seen, radix_writes);
      $display("with stalls on both channels and clamped, spare and noisy register writes.");
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
